// ===== rtl/core/coning_compensation_4sample_unit_assert.svh =====
`ifndef CONING_COMPENSATION_4SAMPLE_UNIT_ASSERT_SVH
`define CONING_COMPENSATION_4SAMPLE_UNIT_ASSERT_SVH

// same-cycle implication, held off while reset is active
`define CC4S_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while reset is active
`define CC4S_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cc4s_pkg.sv =====
package cc4s_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  localparam int CFG_IDX_W = 2;

  localparam int N_COMP         = 3;
  localparam int FRAME_SLOTS    = 4;
  localparam int SLOT_W         = 2;
  localparam int N_FRAME_BUFS   = 2;
  localparam int ROW_DEPTH      = FRAME_SLOTS * N_FRAME_BUFS;
  localparam int ROW_AW         = $clog2(ROW_DEPTH);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAME_SLOTS - 1);

  localparam int STEP_W         = 6;
  localparam int N_SUM_STEPS    = FRAME_SLOTS;
  localparam int PROD_PER_COMP  = 12;
  localparam int N_PROD_STEPS   = PROD_PER_COMP * N_COMP;
  localparam int N_COEF_STEPS   = 9;
  localparam int LINE_DEPTH     = N_COEF_STEPS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAR  = 2'd0,
    REG_SKIP = 2'd1,
    REG_ADJ  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic avail;
    logic rd_buf;
  } queue_status_t;

  typedef struct packed {
    logic [SLOT_W-1:0] row_a;
    logic [SLOT_W-1:0] row_b;
    logic [1:0]        sel_a;
    logic [1:0]        sel_b;
    logic [1:0]        comp;
    logic              neg;
    logic              first;
    logic              last;
  } prod_step_t;

  typedef struct packed {
    logic [1:0] comp;
    reg_idx_t   grp;
  } coef_step_t;

  // product schedule: per component, far pair, then skip pairs, then adjacent pairs
  function automatic prod_step_t prod_step(input logic [STEP_W-1:0] p);
    prod_step_t s;
    logic [1:0] k;
    logic [3:0] r;
    logic [2:0] pair;
    logic [1:0] ci;
    logic [1:0] cj;
    if (p >= STEP_W'(2 * PROD_PER_COMP)) begin
      k = 2'd2;
      r = 4'(p - STEP_W'(2 * PROD_PER_COMP));
    end else if (p >= STEP_W'(PROD_PER_COMP)) begin
      k = 2'd1;
      r = 4'(p - STEP_W'(PROD_PER_COMP));
    end else begin
      k = 2'd0;
      r = 4'(p);
    end
    case (k)
      2'd0: begin
        ci = 2'd1;
        cj = 2'd2;
      end
      2'd1: begin
        ci = 2'd2;
        cj = 2'd0;
      end
      default: begin
        ci = 2'd0;
        cj = 2'd1;
      end
    endcase
    pair    = r[3:1];
    s.comp  = k;
    s.neg   = r[0];
    s.sel_a = r[0] ? cj : ci;
    s.sel_b = r[0] ? ci : cj;
    unique case (pair)
      3'd0: begin
        s.row_a = 2'd0;
        s.row_b = 2'd3;
      end
      3'd1: begin
        s.row_a = 2'd0;
        s.row_b = 2'd2;
      end
      3'd2: begin
        s.row_a = 2'd1;
        s.row_b = 2'd3;
      end
      3'd3: begin
        s.row_a = 2'd0;
        s.row_b = 2'd1;
      end
      3'd4: begin
        s.row_a = 2'd1;
        s.row_b = 2'd2;
      end
      default: begin
        s.row_a = 2'd2;
        s.row_b = 2'd3;
      end
    endcase
    s.first = !r[0] && (pair == 3'd0 || pair == 3'd1 || pair == 3'd3);
    s.last  = r[0] && (pair == 3'd0 || pair == 3'd2 || pair == 3'd5);
    return s;
  endfunction

  // weighting schedule: component-major, far / skip / adjacent within a component
  function automatic coef_step_t coef_step(input logic [3:0] q);
    coef_step_t s;
    logic [3:0] g;
    if (q >= 4'd6) begin
      s.comp = 2'd2;
      g      = q - 4'd6;
    end else if (q >= 4'd3) begin
      s.comp = 2'd1;
      g      = q - 4'd3;
    end else begin
      s.comp = 2'd0;
      g      = q;
    end
    s.grp = reg_idx_t'(g[1:0]);
    return s;
  endfunction

endpackage

// ===== rtl/core/cc4s_ram.sv =====
module cc4s_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/cc4s_front.sv =====
module cc4s_front #(
  parameter int DATA_WIDTH = cc4s_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [DATA_WIDTH-1:0]   in_gyro_dx,
  input  logic signed [DATA_WIDTH-1:0]   in_gyro_dy,
  input  logic signed [DATA_WIDTH-1:0]   in_gyro_dz,
  output logic                           wr_en,
  output logic [cc4s_pkg::ROW_AW-1:0]    wr_addr,
  output logic [3*DATA_WIDTH-1:0]        wr_data,
  input  logic                           pop,
  output cc4s_pkg::queue_status_t        qs
);

  logic [cc4s_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic                        wr_buf_r, wr_buf_nxt;
  logic                        rd_buf_r, rd_buf_nxt;
  logic [1:0]                  cnt_r, cnt_nxt;
  logic                        accept;
  logic                        push;

  assign in_stall = (cnt_r == 2'(cc4s_pkg::N_FRAME_BUFS));
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (slot_r == cc4s_pkg::SLOT_LAST);

  assign wr_en   = accept;
  assign wr_addr = {wr_buf_r, slot_r};
  assign wr_data = {in_gyro_dz, in_gyro_dy, in_gyro_dx};

  always_comb begin
    slot_nxt   = accept ? slot_r + 1'b1 : slot_r;
    wr_buf_nxt = push ? !wr_buf_r : wr_buf_r;
    rd_buf_nxt = pop ? !rd_buf_r : rd_buf_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      wr_buf_r <= 1'b0;
      rd_buf_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      slot_r   <= slot_nxt;
      wr_buf_r <= wr_buf_nxt;
      rd_buf_r <= rd_buf_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign qs.avail  = (cnt_r != 2'd0);
  assign qs.rd_buf = rd_buf_r;

endmodule

// ===== rtl/core/cc4s_mul.sv =====
module cc4s_mul #(
  parameter int DATA_WIDTH = cc4s_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic signed [DATA_WIDTH+3:0]  op_a,
  input  logic signed [DATA_WIDTH-1:0]  op_b,
  output logic signed [DATA_WIDTH+5:0]  prod
);

  localparam int AW = DATA_WIDTH + 4;
  localparam int LW = DATA_WIDTH / 2;
  localparam int HW = DATA_WIDTH - LW;
  localparam int FB = DATA_WIDTH - 2;
  localparam int FW = AW + DATA_WIDTH;
  localparam int PW = DATA_WIDTH + 6;

  logic signed [AW+LW:0]   lo_r, lo_nxt;
  logic signed [AW+HW-1:0] hi_r, hi_nxt;
  logic signed [FW-1:0]    full;
  logic signed [PW-1:0]    prod_r, prod_nxt;

  // split op_b into an unsigned low half and a signed high half
  assign lo_nxt = op_a * $signed({1'b0, op_b[LW-1:0]});
  assign hi_nxt = op_a * $signed(op_b[DATA_WIDTH-1:LW]);

  assign full     = FW'(lo_r) + (FW'(hi_r) <<< LW);
  assign prod_nxt = PW'(full >>> FB);

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

// ===== rtl/core/cc4s_back.sv =====
module cc4s_back #(
  parameter int DATA_WIDTH = cc4s_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cc4s_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [DATA_WIDTH-1:0]             cfg_wdata,
  input  cc4s_pkg::queue_status_t           qs,
  output logic                              pop,
  output logic [cc4s_pkg::ROW_AW-1:0]       rd_addr_a,
  output logic [cc4s_pkg::ROW_AW-1:0]       rd_addr_b,
  input  logic [3*DATA_WIDTH-1:0]           rd_data_a,
  input  logic [3*DATA_WIDTH-1:0]           rd_data_b,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [DATA_WIDTH-1:0]      out_cone_dx,
  output logic signed [DATA_WIDTH-1:0]      out_cone_dy,
  output logic signed [DATA_WIDTH-1:0]      out_cone_dz
);

  localparam int DW = DATA_WIDTH;
  localparam int AW = DW + 4;
  localparam int PW = DW + 6;
  localparam int OW = DW + 8;
  localparam int SW = cc4s_pkg::STEP_W;

  localparam logic signed [OW-1:0] SAT_MAX = {{(OW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [OW-1:0] SAT_MIN = ~SAT_MAX;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SUMS   = 7'b0000010,
    ST_PRODS  = 7'b0000100,
    ST_PDRAIN = 7'b0001000,
    ST_COEFS  = 7'b0010000,
    ST_CDRAIN = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } bk_state_t;

  typedef enum logic [1:0] {
    K_SUM  = 2'd0,
    K_PROD = 2'd1,
    K_COEF = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [1:0]         comp;
    logic [1:0]         sel_a;
    logic [1:0]         sel_b;
    cc4s_pkg::reg_idx_t grp;
    logic               neg;
    logic               first;
    logic               last;
  } tag_t;

  function automatic logic signed [DW-1:0] comp_sel(input logic [3*DW-1:0] row,
                                                    input logic [1:0] c);
    logic signed [DW-1:0] v;
    case (c)
      2'd0:    v = row[DW-1:0];
      2'd1:    v = row[2*DW-1:DW];
      default: v = row[3*DW-1:2*DW];
    endcase
    return v;
  endfunction

  function automatic logic signed [DW-1:0] saturate(input logic signed [OW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > SAT_MAX) begin
      r = DW'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      r = DW'(SAT_MIN);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  bk_state_t               state_r, state_nxt;
  logic [SW-1:0]           step_r, step_nxt;
  logic signed [DW-1:0]    coef_far_r, coef_skip_r, coef_adj_r;
  cc4s_pkg::prod_step_t    ps;
  cc4s_pkg::coef_step_t    cs;
  logic                    iss_v;
  tag_t                    iss_t;
  logic                    clr;
  logic                    emit;
  logic                    pipe_empty;
  logic                    v1_r, v2_r, v3_r;
  tag_t                    t1_r, t2_r, t3_r;
  logic signed [AW-1:0]    op_a;
  logic signed [DW-1:0]    op_b;
  logic                    line_pop;
  logic                    line_push;
  logic signed [PW-1:0]    prod;
  logic signed [AW-1:0]    term;
  logic signed [AW-1:0]    acc_sum;
  logic signed [AW-1:0]    cacc_r, cacc_nxt;
  logic signed [AW-1:0]    line_r [cc4s_pkg::LINE_DEPTH];
  logic signed [OW-1:0]    oacc_r [cc4s_pkg::N_COMP];
  logic signed [OW-1:0]    oacc_nxt [cc4s_pkg::N_COMP];
  logic                    out_valid_r, out_valid_nxt;
  logic signed [DW-1:0]    cone_dx_r, cone_dy_r, cone_dz_r;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_far_r  <= '0;
      coef_skip_r <= '0;
      coef_adj_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cc4s_pkg::REG_FAR:  coef_far_r  <= cfg_wdata;
        cc4s_pkg::REG_SKIP: coef_skip_r <= cfg_wdata;
        cc4s_pkg::REG_ADJ:  coef_adj_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ps         = cc4s_pkg::prod_step(step_r);
  assign cs         = cc4s_pkg::coef_step(step_r[3:0]);
  assign pipe_empty = !v1_r && !v2_r && !v3_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    iss_v     = 1'b0;
    iss_t     = '0;
    rd_addr_a = {qs.rd_buf, cc4s_pkg::SLOT_W'(0)};
    rd_addr_b = {qs.rd_buf, cc4s_pkg::SLOT_W'(0)};
    clr       = 1'b0;
    emit      = 1'b0;
    pop       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (qs.avail) begin
          clr       = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_SUMS;
        end
      end
      ST_SUMS: begin
        iss_v      = 1'b1;
        iss_t.kind = K_SUM;
        rd_addr_a  = {qs.rd_buf, step_r[cc4s_pkg::SLOT_W-1:0]};
        if (step_r == SW'(cc4s_pkg::N_SUM_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_PRODS;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_PRODS: begin
        iss_v       = 1'b1;
        iss_t.kind  = K_PROD;
        iss_t.comp  = ps.comp;
        iss_t.sel_a = ps.sel_a;
        iss_t.sel_b = ps.sel_b;
        iss_t.neg   = ps.neg;
        iss_t.first = ps.first;
        iss_t.last  = ps.last;
        rd_addr_a   = {qs.rd_buf, ps.row_a};
        rd_addr_b   = {qs.rd_buf, ps.row_b};
        if (step_r == SW'(cc4s_pkg::N_PROD_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_PDRAIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_PDRAIN: begin
        if (pipe_empty) begin
          step_nxt  = '0;
          state_nxt = ST_COEFS;
        end
      end
      ST_COEFS: begin
        iss_v      = 1'b1;
        iss_t.kind = K_COEF;
        iss_t.comp = cs.comp;
        iss_t.grp  = cs.grp;
        if (step_r == SW'(cc4s_pkg::N_COEF_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_CDRAIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_CDRAIN: begin
        if (pipe_empty) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          emit      = 1'b1;
          pop       = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      v1_r    <= iss_v;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_r <= iss_t;
    t2_r <= t1_r;
    t3_r <= t2_r;
  end

  // operand select, row data arrives with the first tag stage
  always_comb begin
    op_a     = '0;
    op_b     = '0;
    line_pop = 1'b0;
    case (t1_r.kind)
      K_PROD: begin
        op_a = AW'(comp_sel(rd_data_a, t1_r.sel_a));
        op_b = comp_sel(rd_data_b, t1_r.sel_b);
      end
      K_COEF: begin
        op_a     = line_r[0];
        line_pop = v1_r;
        unique case (t1_r.grp)
          cc4s_pkg::REG_FAR:  op_b = coef_far_r;
          cc4s_pkg::REG_SKIP: op_b = coef_skip_r;
          cc4s_pkg::REG_ADJ:  op_b = coef_adj_r;
          default:            op_b = '0;
        endcase
      end
      default: ;
    endcase
  end

  cc4s_mul #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // cross-product accumulation
  always_comb begin
    term      = t3_r.neg ? -AW'(prod) : AW'(prod);
    acc_sum   = (t3_r.first ? AW'(0) : cacc_r) + term;
    cacc_nxt  = cacc_r;
    line_push = 1'b0;
    if (v3_r && t3_r.kind == K_PROD) begin
      cacc_nxt  = acc_sum;
      line_push = t3_r.last;
    end
  end

  always_ff @(posedge clk) begin
    cacc_r <= cacc_nxt;
    if (line_push || line_pop) begin
      for (int i = 0; i < cc4s_pkg::LINE_DEPTH - 1; i++) begin
        line_r[i] <= line_r[i+1];
      end
      line_r[cc4s_pkg::LINE_DEPTH-1] <= acc_sum;
    end
  end

  // frame sum accumulation
  always_comb begin
    for (int c = 0; c < cc4s_pkg::N_COMP; c++) begin
      oacc_nxt[c] = oacc_r[c];
      if (clr) begin
        oacc_nxt[c] = '0;
      end else if (v1_r && t1_r.kind == K_SUM) begin
        oacc_nxt[c] = oacc_r[c] + OW'(comp_sel(rd_data_a, 2'(c)));
      end else if (v3_r && t3_r.kind == K_COEF && t3_r.comp == 2'(c)) begin
        oacc_nxt[c] = oacc_r[c] + OW'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < cc4s_pkg::N_COMP; c++) begin
      oacc_r[c] <= oacc_nxt[c];
    end
  end

  // output register
  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cone_dx_r <= saturate(oacc_r[0]);
      cone_dy_r <= saturate(oacc_r[1]);
      cone_dz_r <= saturate(oacc_r[2]);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_cone_dx = cone_dx_r;
  assign out_cone_dy = cone_dy_r;
  assign out_cone_dz = cone_dz_r;

endmodule

// ===== rtl/core/coning_compensation_4sample_unit.sv =====
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_gyro_dx, in_gyro_dy, in_gyro_dz
// out_      output     out_valid/out_stall  out_cone_dx, out_cone_dy, out_cone_dz
// cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// Samples are taken one per cycle while one of the two frame buffers is free.
// Each complete frame then occupies the back end for 4 sums, 36 sample products,
// 9 weightings, pipeline drains and output, set by the one shared two-stage
// multiplier issuing one product a cycle.
// Synchronous active-low reset clears the frame counters, coefficients and valids.
// A stalled output holds the back end; in_stall rises while both buffers hold frames.

`include "coning_compensation_4sample_unit_assert.svh"

module coning_compensation_4sample_unit #(
  parameter int DATA_WIDTH = cc4s_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [DATA_WIDTH-1:0]     in_gyro_dx,
  input  logic signed [DATA_WIDTH-1:0]     in_gyro_dy,
  input  logic signed [DATA_WIDTH-1:0]     in_gyro_dz,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [DATA_WIDTH-1:0]     out_cone_dx,
  output logic signed [DATA_WIDTH-1:0]     out_cone_dy,
  output logic signed [DATA_WIDTH-1:0]     out_cone_dz,
  input  logic                             cfg_we,
  input  logic [cc4s_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_WIDTH-1:0]            cfg_wdata
);

  logic                          wr_en;
  logic [cc4s_pkg::ROW_AW-1:0]   wr_addr;
  logic [3*DATA_WIDTH-1:0]       wr_data;
  logic [cc4s_pkg::ROW_AW-1:0]   rd_addr_a;
  logic [cc4s_pkg::ROW_AW-1:0]   rd_addr_b;
  logic [3*DATA_WIDTH-1:0]       rd_data_a;
  logic [3*DATA_WIDTH-1:0]       rd_data_b;
  logic                          pop;
  cc4s_pkg::queue_status_t       qs;

  cc4s_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_gyro_dx (in_gyro_dx),
    .in_gyro_dy (in_gyro_dy),
    .in_gyro_dz (in_gyro_dz),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .pop        (pop),
    .qs         (qs)
  );

  cc4s_ram #(
    .WIDTH(3 * DATA_WIDTH),
    .DEPTH(cc4s_pkg::ROW_DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr_a),
    .rdata (rd_data_a)
  );

  cc4s_ram #(
    .WIDTH(3 * DATA_WIDTH),
    .DEPTH(cc4s_pkg::ROW_DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr_b),
    .rdata (rd_data_b)
  );

  cc4s_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .qs          (qs),
    .pop         (pop),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .rd_data_a   (rd_data_a),
    .rd_data_b   (rd_data_b),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_cone_dx (out_cone_dx),
    .out_cone_dy (out_cone_dy),
    .out_cone_dz (out_cone_dz)
  );

  `CC4S_ASSERT_IMP(a_pop_needs_frame, clk, rst_n, pop, qs.avail, "frame released while none is buffered")
  `CC4S_ASSERT_NXT(a_pop_loads_out, clk, rst_n, pop, out_valid, "frame released without a transaction")
  `CC4S_ASSERT_IMP(a_avail_fall_on_pop, clk, rst_n, $fell(qs.avail), $past(pop), "frame queue emptied without a release")

endmodule
